>>> rtl/ipdr_pkg.sv
// shared types, constants and tables for the planar imu dead reckoning block
`timescale 1ns / 1ps

package ipdr_pkg;

  // serial multiplier operand width (magnitude of a 49-bit signed value)
  localparam int MUL_W = 49;
  // serial divider widths
  localparam int DIV_N = 78;
  localparam int DIV_D = 54;

  localparam int CORDIC_STEPS = 30;

  localparam logic [29:0] NS_PER_S    = 30'd1000000000;
  localparam logic [45:0] DT_CAP_NS   = 46'd65535999999999;
  localparam logic [33:0] PI_Q32      = 34'd13493037705;
  localparam logic [34:0] TWO_PI_Q32  = 35'd26986075409;
  localparam logic [32:0] HALF_PI_Q32 = 33'd6746518852;
  localparam logic [29:0] CORDIC_GAIN = 30'd652032874;

  // right shift applied to a product
  typedef enum logic [1:0] {
    SH_0,
    SH_24,
    SH_30,
    SH_32
  } shift_t;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_CUR,
    S_DT,
    S_DTDIV,
    S_RING,
    S_AVG,
    S_YMUL,
    S_YDIV,
    S_FWD,
    S_SIDE,
    S_HEAD,
    S_MOD,
    S_RED,
    S_CORD,
    S_CS,
    S_VE1,
    S_VE2,
    S_VN1,
    S_VN2,
    S_PE,
    S_PN,
    S_OUT
  } state_t;

  // arctangent of 2^-i in q2.30
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd7;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/ipdr_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module ipdr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 20
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ipdr_mul.sv
// bit-serial sign-magnitude multiplier with truncating shift and 48-bit saturation
`timescale 1ns / 1ps

module ipdr_mul (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [ipdr_pkg::MUL_W-1:0] a,
  input  logic signed [ipdr_pkg::MUL_W-1:0] b,
  input  ipdr_pkg::shift_t                 sh,
  output logic                             done,
  output logic [2*ipdr_pkg::MUL_W-1:0]     prod,
  output logic signed [47:0]               res
);

  localparam int W = ipdr_pkg::MUL_W;
  localparam int CW = $clog2(W);

  logic [W-1:0]     mcand;
  logic [W-1:0]     acc;
  logic [W-1:0]     low;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             neg;
  ipdr_pkg::shift_t sh_r;

  logic [W:0]       sum;
  logic [2*W-1:0]   shifted;
  logic [47:0]      lim;
  logic [47:0]      smag;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  // one multiplier bit per cycle
  assign sum = {1'b0, acc} + (low[0] ? {1'b0, mcand} : {(W+1){1'b0}});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= '0;
        mcand <= mag(a);
        low  <= mag(b);
        neg  <= a[W-1] ^ b[W-1];
        sh_r <= sh;
      end else if (busy) begin
        acc <= sum[W:1];
        low <= {sum[0], low[W-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = {acc, low};

  // truncating shift, then clamp and apply sign
  always_comb begin
    unique case (sh_r)
      ipdr_pkg::SH_0:  shifted = prod;
      ipdr_pkg::SH_24: shifted = prod >> 24;
      ipdr_pkg::SH_30: shifted = prod >> 30;
      ipdr_pkg::SH_32: shifted = prod >> 32;
      default:         shifted = prod;
    endcase
    lim  = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    smag = (shifted > {{(2*W-48){1'b0}}, lim}) ? lim : shifted[47:0];
    res  = neg ? $signed(-smag) : $signed(smag);
  end

endmodule

>>> rtl/ipdr_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module ipdr_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ipdr_pkg::DIV_N-1:0] dividend,
  input  logic [ipdr_pkg::DIV_D-1:0] divisor,
  output logic                       done,
  output logic [ipdr_pkg::DIV_N-1:0] quo,
  output logic [ipdr_pkg::DIV_D-1:0] rem
);

  localparam int N = ipdr_pkg::DIV_N;
  localparam int D = ipdr_pkg::DIV_D;
  localparam int CW = $clog2(N);

  logic [D-1:0]  dsor;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [D:0]    trial;
  logic          qbit;

  // shift in next dividend bit and try a subtract
  assign trial = {rem, quo[N-1]};
  assign qbit  = (trial >= {1'b0, dsor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= dividend;
        rem  <= '0;
        dsor <= divisor;
      end else if (busy) begin
        rem <= qbit ? D'(trial - {1'b0, dsor}) : trial[D-1:0];
        quo <= {quo[N-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(N-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/imu_planar_dead_reckoning.sv
// top level: planar imu dead reckoning sequencer with moving-average yaw rate
//
// Usage: one imu sample item enters on the input channel (in_valid / in_stall)
// and exactly one result item leaves on the output channel (out_valid /
// out_stall). The input takes an item only while the sequencer is idle; a
// finished result sits in the output register, so the next item is taken
// while the previous result still waits for the receiver.
// The processing time of an item is set by the shared bit-serial multiplier
// (eleven products), the shared bit-serial divider (four quotients: time step,
// average, yaw acceleration, heading reduction) and thirty cordic iterations;
// a zero time step skips the yaw acceleration product and quotient. A new
// item is taken only after the previous item's work is done.
// Reset (rst, synchronous) clears all integrators, the timestamp history, the
// ring valid bits and both handshakes; no clearing pass is needed.
// When the receiver stalls, the result holds on the ports and the sequencer
// waits in its final state with the next item's work done.
`timescale 1ns / 1ps

module imu_planar_dead_reckoning #(
  parameter int WINDOW = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        stamp_sec,
  input  logic [29:0]        stamp_nanosec,
  input  logic signed [31:0] accel_fwd,
  input  logic signed [31:0] accel_side,
  input  logic signed [31:0] yaw_rate_raw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_sec,
  output logic [29:0]        out_nanosec,
  output logic signed [47:0] pos_east,
  output logic signed [47:0] pos_north,
  output logic signed [47:0] heading,
  output logic signed [47:0] vel_fwd,
  output logic signed [47:0] vel_side,
  output logic signed [31:0] yaw_rate_avg,
  output logic signed [31:0] accel_fwd_out,
  output logic signed [31:0] accel_side_out,
  output logic signed [31:0] yaw_accel
);

  localparam int MW = ipdr_pkg::MUL_W;
  localparam int DN = ipdr_pkg::DIV_N;
  localparam int DD = ipdr_pkg::DIV_D;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W = 32 + $clog2(WINDOW) + 1;

  ipdr_pkg::state_t state, state_next;

  // latched item
  logic [31:0]        sec;
  logic [29:0]        nsec;
  logic signed [31:0] af;
  logic signed [31:0] as_r;
  logic signed [31:0] rr;

  // persistent state
  logic [61:0]        prev_ns;
  logic               seen_first;
  logic signed [47:0] east_acc;
  logic signed [47:0] north_acc;
  logic signed [47:0] heading_acc;
  logic signed [47:0] fwd_speed;
  logic signed [47:0] side_speed;
  logic signed [31:0] prev_rate_avg;
  logic [SLOT_W-1:0]  ring_slot;
  logic [WINDOW-1:0]  ring_valid;
  logic signed [SUM_W-1:0] ring_sum;

  // per-item temporaries
  logic [61:0]        cur_ns;
  logic [45:0]        dt_ns;
  logic [47:0]        dt;
  logic signed [31:0] avg;
  logic signed [32:0] diff;
  logic signed [31:0] yacc;
  logic [34:0]        red_r;
  logic signed [33:0] cx;
  logic signed [33:0] cy;
  logic signed [35:0] cz;
  logic [4:0]         iter;
  logic signed [33:0] cos_v;
  logic signed [33:0] sin_v;
  logic signed [47:0] t1;
  logic signed [47:0] ve;
  logic signed [47:0] vn;
  logic               unit_wait;

  // arithmetic unit hookup
  logic                 mul_go;
  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  ipdr_pkg::shift_t     mul_sh;
  logic                 mul_done;
  logic [2*MW-1:0]      mul_prod;
  logic signed [47:0]   mul_res;

  logic          div_go;
  logic [DN-1:0] div_num;
  logic [DD-1:0] div_den;
  logic          div_done;
  logic [DN-1:0] div_quo;
  logic [DD-1:0] div_rem;

  logic [31:0] ring_rdata;
  logic        ring_we;

  // combinational helpers
  logic signed [48:0]      tsum;
  logic [48:0]             tmag;
  logic [SUM_W-1:0]        sum_mag;
  logic [32:0]             diff_mag;
  logic signed [SUM_W-1:0] ring_old;
  logic signed [31:0]      avg_q;
  logic signed [35:0]      red0;
  logic signed [35:0]      red1;
  logic                    red_flip;
  logic signed [35:0]      atan_x;
  logic                    out_free;

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    if (v > 50'sh0_7FFF_FFFF_FFFF) begin
      return 48'sh7FFF_FFFF_FFFF;
    end else if (v < -50'sh0_8000_0000_0000) begin
      return 48'sh8000_0000_0000;
    end
    return v[47:0];
  endfunction

  ipdr_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .sh    (mul_sh),
    .done  (mul_done),
    .prod  (mul_prod),
    .res   (mul_res)
  );

  ipdr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  ipdr_ram #(
    .WIDTH (32),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_slot),
    .wdata (rr),
    .raddr (ring_slot),
    .rdata (ring_rdata)
  );

  assign in_stall = rst || (state != ipdr_pkg::S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign ring_we  = (state == ipdr_pkg::S_RING);

  // datapath helpers
  always_comb begin
    tsum     = 49'(heading_acc) + $signed({15'd0, ipdr_pkg::PI_Q32});
    tmag     = tsum[48] ? 49'(-tsum) : 49'(tsum);
    sum_mag  = ring_sum[SUM_W-1] ? SUM_W'(-ring_sum) : SUM_W'(ring_sum);
    diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    ring_old = ring_valid[ring_slot] ? SUM_W'($signed(ring_rdata)) : '0;
    avg_q    = ring_sum[SUM_W-1] ? 32'(-div_quo[31:0]) : div_quo[31:0];
    red0     = $signed({1'b0, red_r}) - $signed({2'b00, ipdr_pkg::PI_Q32});
    red_flip = 1'b0;
    red1     = red0;
    if (red0 > $signed({3'b000, ipdr_pkg::HALF_PI_Q32})) begin
      red1     = red0 - $signed({2'b00, ipdr_pkg::PI_Q32});
      red_flip = 1'b1;
    end else if (red0 < -$signed({3'b000, ipdr_pkg::HALF_PI_Q32})) begin
      red1     = red0 + $signed({2'b00, ipdr_pkg::PI_Q32});
      red_flip = 1'b1;
    end
    atan_x = $signed({6'd0, ipdr_pkg::atan_q30(iter)});
  end

  logic flip;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ipdr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and unit control
  always_comb begin
    state_next = state;
    mul_go  = 1'b0;
    div_go  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    mul_sh  = ipdr_pkg::SH_0;
    div_num = '0;
    div_den = '0;
    unique case (state)
      ipdr_pkg::S_IDLE: begin
        if (in_valid) state_next = ipdr_pkg::S_CUR;
      end
      ipdr_pkg::S_CUR: begin
        mul_go = !unit_wait;
        mul_a  = MW'({1'b0, sec});
        mul_b  = MW'({1'b0, ipdr_pkg::NS_PER_S});
        if (mul_done) state_next = ipdr_pkg::S_DT;
      end
      ipdr_pkg::S_DT: begin
        state_next = ipdr_pkg::S_DTDIV;
      end
      ipdr_pkg::S_DTDIV: begin
        div_go  = !unit_wait;
        div_num = {dt_ns, 32'd0};
        div_den = DD'(ipdr_pkg::NS_PER_S);
        if (div_done) state_next = ipdr_pkg::S_RING;
      end
      ipdr_pkg::S_RING: begin
        state_next = ipdr_pkg::S_AVG;
      end
      ipdr_pkg::S_AVG: begin
        div_go  = !unit_wait;
        div_num = DN'(sum_mag);
        div_den = DD'(WINDOW);
        if (div_done) begin
          state_next = (dt_ns == '0) ? ipdr_pkg::S_FWD : ipdr_pkg::S_YMUL;
        end
      end
      ipdr_pkg::S_YMUL: begin
        mul_go = !unit_wait;
        mul_a  = MW'(diff_mag);
        mul_b  = MW'({1'b0, ipdr_pkg::NS_PER_S});
        if (mul_done) state_next = ipdr_pkg::S_YDIV;
      end
      ipdr_pkg::S_YDIV: begin
        div_go  = !unit_wait;
        div_num = DN'(mul_prod[62:0]);
        div_den = {dt_ns, 8'd0};
        if (div_done) state_next = ipdr_pkg::S_FWD;
      end
      ipdr_pkg::S_FWD: begin
        mul_go = !unit_wait;
        mul_a  = MW'(af);
        mul_b  = MW'({1'b0, dt});
        mul_sh = ipdr_pkg::SH_32;
        if (mul_done) state_next = ipdr_pkg::S_SIDE;
      end
      ipdr_pkg::S_SIDE: begin
        mul_go = !unit_wait;
        mul_a  = MW'(as_r);
        mul_b  = MW'({1'b0, dt});
        mul_sh = ipdr_pkg::SH_32;
        if (mul_done) state_next = ipdr_pkg::S_HEAD;
      end
      ipdr_pkg::S_HEAD: begin
        mul_go = !unit_wait;
        mul_a  = MW'(avg);
        mul_b  = MW'({1'b0, dt});
        mul_sh = ipdr_pkg::SH_24;
        if (mul_done) state_next = ipdr_pkg::S_MOD;
      end
      ipdr_pkg::S_MOD: begin
        div_go  = !unit_wait;
        div_num = DN'(tmag);
        div_den = DD'(ipdr_pkg::TWO_PI_Q32);
        if (div_done) state_next = ipdr_pkg::S_RED;
      end
      ipdr_pkg::S_RED: begin
        state_next = ipdr_pkg::S_CORD;
      end
      ipdr_pkg::S_CORD: begin
        if (iter == 5'(ipdr_pkg::CORDIC_STEPS - 1)) state_next = ipdr_pkg::S_CS;
      end
      ipdr_pkg::S_CS: begin
        state_next = ipdr_pkg::S_VE1;
      end
      ipdr_pkg::S_VE1: begin
        mul_go = !unit_wait;
        mul_a  = MW'(fwd_speed);
        mul_b  = MW'(cos_v);
        mul_sh = ipdr_pkg::SH_30;
        if (mul_done) state_next = ipdr_pkg::S_VE2;
      end
      ipdr_pkg::S_VE2: begin
        mul_go = !unit_wait;
        mul_a  = MW'(side_speed);
        mul_b  = MW'(sin_v);
        mul_sh = ipdr_pkg::SH_30;
        if (mul_done) state_next = ipdr_pkg::S_VN1;
      end
      ipdr_pkg::S_VN1: begin
        mul_go = !unit_wait;
        mul_a  = MW'(fwd_speed);
        mul_b  = MW'(sin_v);
        mul_sh = ipdr_pkg::SH_30;
        if (mul_done) state_next = ipdr_pkg::S_VN2;
      end
      ipdr_pkg::S_VN2: begin
        mul_go = !unit_wait;
        mul_a  = MW'(side_speed);
        mul_b  = MW'(cos_v);
        mul_sh = ipdr_pkg::SH_30;
        if (mul_done) state_next = ipdr_pkg::S_PE;
      end
      ipdr_pkg::S_PE: begin
        mul_go = !unit_wait;
        mul_a  = MW'(ve);
        mul_b  = MW'({1'b0, dt});
        mul_sh = ipdr_pkg::SH_32;
        if (mul_done) state_next = ipdr_pkg::S_PN;
      end
      ipdr_pkg::S_PN: begin
        mul_go = !unit_wait;
        mul_a  = MW'(vn);
        mul_b  = MW'({1'b0, dt});
        mul_sh = ipdr_pkg::SH_32;
        if (mul_done) state_next = ipdr_pkg::S_OUT;
      end
      ipdr_pkg::S_OUT: begin
        if (out_free) state_next = ipdr_pkg::S_IDLE;
      end
      default: state_next = ipdr_pkg::S_IDLE;
    endcase
  end

  // control state: handshakes, history, integrators
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_wait     <= 1'b0;
      out_valid     <= 1'b0;
      prev_ns       <= '0;
      seen_first    <= 1'b0;
      east_acc      <= '0;
      north_acc     <= '0;
      heading_acc   <= '0;
      fwd_speed     <= '0;
      side_speed    <= '0;
      prev_rate_avg <= '0;
      ring_slot     <= '0;
      ring_valid    <= '0;
      ring_sum      <= '0;
    end else begin
      // unit launch bookkeeping
      if (mul_go || div_go) begin
        unit_wait <= 1'b1;
      end else if (mul_done || div_done) begin
        unit_wait <= 1'b0;
      end

      // output register
      if (state == ipdr_pkg::S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ipdr_pkg::S_DT: begin
          prev_ns    <= cur_ns;
          seen_first <= 1'b1;
        end
        ipdr_pkg::S_RING: begin
          ring_sum  <= ring_sum + SUM_W'(rr) - ring_old;
          ring_valid[ring_slot] <= 1'b1;
          ring_slot <= (ring_slot == SLOT_W'(WINDOW - 1)) ? '0 : ring_slot + 1'b1;
        end
        ipdr_pkg::S_AVG: begin
          if (div_done) prev_rate_avg <= avg_q;
        end
        ipdr_pkg::S_FWD: begin
          if (mul_done) fwd_speed <= sat48(50'(fwd_speed) + 50'(mul_res));
        end
        ipdr_pkg::S_SIDE: begin
          if (mul_done) side_speed <= sat48(50'(side_speed) + 50'(mul_res));
        end
        ipdr_pkg::S_HEAD: begin
          if (mul_done) heading_acc <= sat48(50'(heading_acc) + 50'(mul_res));
        end
        ipdr_pkg::S_PE: begin
          if (mul_done) east_acc <= sat48(50'(east_acc) + 50'(mul_res));
        end
        ipdr_pkg::S_PN: begin
          if (mul_done) north_acc <= sat48(50'(north_acc) + 50'(mul_res));
        end
        default: begin
        end
      endcase
    end
  end

  // per-item payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      ipdr_pkg::S_IDLE: begin
        if (in_valid) begin
          sec  <= stamp_sec;
          nsec <= stamp_nanosec;
          af   <= accel_fwd;
          as_r <= accel_side;
          rr   <= yaw_rate_raw;
        end
      end
      ipdr_pkg::S_CUR: begin
        if (mul_done) cur_ns <= mul_prod[61:0] + 62'(nsec);
      end
      ipdr_pkg::S_DT: begin
        // zero on the first sample or a backward step, capped when very long
        if (!seen_first || cur_ns <= prev_ns) begin
          dt_ns <= '0;
        end else if ((cur_ns - prev_ns) > 62'(ipdr_pkg::DT_CAP_NS)) begin
          dt_ns <= ipdr_pkg::DT_CAP_NS;
        end else begin
          dt_ns <= 46'(cur_ns - prev_ns);
        end
      end
      ipdr_pkg::S_DTDIV: begin
        if (div_done) dt <= div_quo[47:0];
      end
      ipdr_pkg::S_AVG: begin
        if (div_done) begin
          avg  <= avg_q;
          diff <= 33'(avg_q) - 33'(prev_rate_avg);
          yacc <= '0;
        end
      end
      ipdr_pkg::S_YDIV: begin
        // sign and clamp the yaw acceleration quotient
        if (div_done) begin
          if (diff[32]) begin
            yacc <= (div_quo > DN'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                     : 32'(-div_quo[31:0]);
          end else begin
            yacc <= (div_quo > DN'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : div_quo[31:0];
          end
        end
      end
      ipdr_pkg::S_MOD: begin
        // floor remainder of heading plus pi over two pi
        if (div_done) begin
          if (tsum[48] && div_rem != '0) begin
            red_r <= ipdr_pkg::TWO_PI_Q32 - div_rem[34:0];
          end else begin
            red_r <= div_rem[34:0];
          end
        end
      end
      ipdr_pkg::S_RED: begin
        flip <= red_flip;
        cx   <= 34'(ipdr_pkg::CORDIC_GAIN);
        cy   <= '0;
        cz   <= red1 >>> 2;
        iter <= '0;
      end
      ipdr_pkg::S_CORD: begin
        // one rotation per cycle
        if (!cz[35]) begin
          cx <= cx - (cy >>> iter);
          cy <= cy + (cx >>> iter);
          cz <= cz - atan_x;
        end else begin
          cx <= cx + (cy >>> iter);
          cy <= cy - (cx >>> iter);
          cz <= cz + atan_x;
        end
        iter <= iter + 1'b1;
      end
      ipdr_pkg::S_CS: begin
        cos_v <= flip ? -cx : cx;
        sin_v <= flip ? -cy : cy;
      end
      ipdr_pkg::S_VE1: begin
        if (mul_done) t1 <= mul_res;
      end
      ipdr_pkg::S_VE2: begin
        if (mul_done) ve <= sat48(50'(t1) - 50'(mul_res));
      end
      ipdr_pkg::S_VN1: begin
        if (mul_done) t1 <= mul_res;
      end
      ipdr_pkg::S_VN2: begin
        if (mul_done) vn <= sat48(50'(t1) + 50'(mul_res));
      end
      ipdr_pkg::S_OUT: begin
        if (out_free) begin
          out_sec        <= sec;
          out_nanosec    <= nsec;
          pos_east       <= east_acc;
          pos_north      <= north_acc;
          heading        <= heading_acc;
          vel_fwd        <= fwd_speed;
          vel_side       <= side_speed;
          yaw_rate_avg   <= avg;
          accel_fwd_out  <= af;
          accel_side_out <= as_r;
          yaw_accel      <= yacc;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sim/tb_top.sv
// self-checking testbench for the planar imu dead reckoning block
`timescale 1ns / 1ps

module tb_top;

  localparam int WINDOW = 20;
  localparam longint LIM48 = 64'sd140737488355327;
  localparam longint PI_Q = 64'sd13493037705;
  localparam longint TWO_PI_Q = 64'sd26986075409;
  localparam longint HALF_PI_Q = 64'sd6746518852;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam bit [63:0] NS_SEC = 64'd1000000000;
  localparam bit [63:0] DT_LIMIT_NS = 64'd65535999999999;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 2000;
  localparam int HOLD_CYCLES = 4000;

  // one result item as seen on the output ports
  typedef struct packed {
    logic [31:0] sec;
    logic [29:0] nanosec;
    logic [47:0] east;
    logic [47:0] north;
    logic [47:0] hdg;
    logic [47:0] vfwd;
    logic [47:0] vside;
    logic [31:0] rate_avg;
    logic [31:0] afwd;
    logic [31:0] aside;
    logic [31:0] yacc;
  } nav_result_t;

  // predictor of the navigation state plus the queue of pending results
  class nav_scoreboard;
    bit [31:0] last_sec;
    bit [29:0] last_nsec;
    bit have_first;
    longint east_pos, north_pos, hdg_q32, speed_fwd, speed_side, last_avg, rate_sum;
    int slot;
    longint rate_hist[WINDOW];
    nav_result_t pending_results[$];
    int errors;
    int checked;

    function new();
      last_sec = 0;
      last_nsec = 0;
      have_first = 0;
      east_pos = 0;
      north_pos = 0;
      hdg_q32 = 0;
      speed_fwd = 0;
      speed_side = 0;
      last_avg = 0;
      rate_sum = 0;
      slot = 0;
      foreach (rate_hist[i]) rate_hist[i] = 0;
      errors = 0;
      checked = 0;
    endfunction

    function longint clamp48(longint v);
      if (v > LIM48) return LIM48;
      if (v < -LIM48 - 1) return -LIM48 - 1;
      return v;
    endfunction

    function bit [63:0] magnitude(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // truncating signed product with right shift, clamped to 48 bits
    function longint scaled_product(longint a, longint b, int sh);
      bit [127:0] p;
      bit [127:0] r;
      bit [127:0] lim;
      bit neg;
      neg = (a < 0) != (b < 0);
      p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
      r = p >> sh;
      lim = neg ? 128'(LIM48 + 1) : 128'(LIM48);
      if (r > lim) r = lim;
      return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
    endfunction

    // cordic cosine and sine of a q16.32 heading, q2.30 results
    function void heading_trig(longint h, output longint c, output longint s);
      longint t, k, red, x, y, z, dx, dy;
      bit flip;
      t = h + PI_Q;
      flip = 0;
      if (t >= 0) k = t / TWO_PI_Q;
      else k = -((-t + TWO_PI_Q - 1) / TWO_PI_Q);
      red = h - k * TWO_PI_Q;
      if (red > HALF_PI_Q) begin
        red -= PI_Q;
        flip = 1;
      end else if (red < -HALF_PI_Q) begin
        red += PI_Q;
        flip = 1;
      end
      x = GAIN_Q30;
      y = 0;
      z = red >>> 2;
      for (int i = 0; i < ipdr_pkg::CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= longint'(ipdr_pkg::atan_q30(5'(i)));
        end else begin
          x += dx;
          y -= dy;
          z += longint'(ipdr_pkg::atan_q30(5'(i)));
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    // accepted sample: advance the navigation state and queue the result
    function void note_sample(bit [31:0] sec, bit [29:0] nsec, bit [31:0] af,
                              bit [31:0] as, bit [31:0] rr);
      bit [63:0] cur_ns, prev_ns, dt_ns, q;
      longint dt, avg, yacc, diff, c, s, ve, vn, afs, ass, rrs;
      nav_result_t res;
      afs = longint'(signed'(af));
      ass = longint'(signed'(as));
      rrs = longint'(signed'(rr));
      cur_ns = 64'(sec) * NS_SEC + 64'(nsec);
      prev_ns = 64'(last_sec) * NS_SEC + 64'(last_nsec);
      dt_ns = 0;
      yacc = 0;
      if (have_first && cur_ns > prev_ns) dt_ns = cur_ns - prev_ns;
      if (dt_ns > DT_LIMIT_NS) dt_ns = DT_LIMIT_NS;
      have_first = 1;
      last_sec = sec;
      last_nsec = nsec;
      dt = longint'(((dt_ns / NS_SEC) << 32) + ((dt_ns % NS_SEC) << 32) / NS_SEC);
      // moving average over the ring
      rate_sum += rrs - rate_hist[slot];
      rate_hist[slot] = rrs;
      slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
      avg = rate_sum / WINDOW;
      diff = avg - last_avg;
      last_avg = avg;
      if (dt_ns != 0) begin
        q = (magnitude(diff) * NS_SEC) / (dt_ns * 64'd256);
        if (diff < 0) yacc = (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
        else yacc = (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
      end
      // integrate body velocity, heading, then world position
      speed_fwd = clamp48(speed_fwd + scaled_product(afs, dt, 32));
      speed_side = clamp48(speed_side + scaled_product(ass, dt, 32));
      hdg_q32 = clamp48(hdg_q32 + scaled_product(avg, dt, 24));
      heading_trig(hdg_q32, c, s);
      ve = clamp48(scaled_product(speed_fwd, c, 30) - scaled_product(speed_side, s, 30));
      vn = clamp48(scaled_product(speed_fwd, s, 30) + scaled_product(speed_side, c, 30));
      east_pos = clamp48(east_pos + scaled_product(ve, dt, 32));
      north_pos = clamp48(north_pos + scaled_product(vn, dt, 32));
      res.sec = sec;
      res.nanosec = nsec;
      res.east = east_pos[47:0];
      res.north = north_pos[47:0];
      res.hdg = hdg_q32[47:0];
      res.vfwd = speed_fwd[47:0];
      res.vside = speed_side[47:0];
      res.rate_avg = avg[31:0];
      res.afwd = af;
      res.aside = as;
      res.yacc = yacc[31:0];
      pending_results.push_back(res);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on result %0d: %s got %0h expected %0h", checked, what, got, want);
      errors++;
    endtask

    // compare one result item with the oldest pending one
    task check_result(nav_result_t got);
      nav_result_t want;
      if (pending_results.size() == 0) begin
        $display("result item with nothing pending");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.sec !== want.sec) report("out_sec", got.sec, want.sec);
      if (got.nanosec !== want.nanosec) report("out_nanosec", got.nanosec, want.nanosec);
      if (got.east !== want.east) report("pos_east", got.east, want.east);
      if (got.north !== want.north) report("pos_north", got.north, want.north);
      if (got.hdg !== want.hdg) report("heading", got.hdg, want.hdg);
      if (got.vfwd !== want.vfwd) report("vel_fwd", got.vfwd, want.vfwd);
      if (got.vside !== want.vside) report("vel_side", got.vside, want.vside);
      if (got.rate_avg !== want.rate_avg) report("yaw_rate_avg", got.rate_avg, want.rate_avg);
      if (got.afwd !== want.afwd) report("accel_fwd_out", got.afwd, want.afwd);
      if (got.aside !== want.aside) report("accel_side_out", got.aside, want.aside);
      if (got.yacc !== want.yacc) report("yaw_accel", got.yacc, want.yacc);
      checked++;
    endtask
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [31:0] stamp_sec;
  logic [29:0] stamp_nanosec;
  logic signed [31:0] accel_fwd;
  logic signed [31:0] accel_side;
  logic signed [31:0] yaw_rate_raw;
  logic out_valid;
  logic out_stall;
  logic [31:0] out_sec;
  logic [29:0] out_nanosec;
  logic signed [47:0] pos_east;
  logic signed [47:0] pos_north;
  logic signed [47:0] heading;
  logic signed [47:0] vel_fwd;
  logic signed [47:0] vel_side;
  logic signed [31:0] yaw_rate_avg;
  logic signed [31:0] accel_fwd_out;
  logic signed [31:0] accel_side_out;
  logic signed [31:0] yaw_accel;

  nav_scoreboard sb;
  int sender_idle_pct;
  int receiver_idle_pct;
  bit hold_receiver;
  int progress;
  int samples_sent;
  bit [31:0] clock_sec;
  bit [29:0] clock_nsec;

  imu_planar_dead_reckoning #(.WINDOW(WINDOW)) dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // offer one sample item and wait for it to be taken
  task send_sample(bit [31:0] sec, bit [29:0] nsec, bit [31:0] af, bit [31:0] as,
                   bit [31:0] rr);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    stamp_sec <= sec;
    stamp_nanosec <= nsec;
    accel_fwd <= af;
    accel_side <= as;
    yaw_rate_raw <= rr;
    do @(posedge clk); while (in_stall);
    sb.note_sample(sec, nsec, af, as, rr);
    progress++;
    samples_sent++;
  endtask

  function bit [31:0] pick_accel();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 32'($signed($urandom_range(2097152)) - 1048576);
    if (r < 90) return $urandom;
    return ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
  endfunction

  function bit [31:0] pick_rate();
    int r;
    r = $urandom_range(99);
    if (r < 75) return 32'($signed($urandom_range(67108864)) - 33554432);
    if (r < 92) return $urandom;
    return ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
  endfunction

  // advance the sample clock, mostly by up to 50 ms with odd jumps
  task random_sample();
    int r;
    bit [63:0] ns;
    r = $urandom_range(99);
    if (r < 5) begin
      // repeated stamp
    end else if (r < 8) begin
      if (clock_nsec >= 30'd50000000) clock_nsec -= 30'($urandom_range(50000000));
      else clock_sec -= 1;
    end else if (r < 10) begin
      clock_sec += $urandom_range(100000);
    end else if (r < 13) begin
      clock_sec = $urandom;
      clock_nsec = 30'($urandom);
    end else begin
      ns = 64'(clock_nsec) + 64'($urandom_range(50000000, 1));
      if (clock_nsec < 30'd1000000000) begin
        clock_sec += 32'(ns / NS_SEC);
        clock_nsec = 30'(ns % NS_SEC);
      end else begin
        clock_nsec = 30'(ns % NS_SEC);
      end
    end
    send_sample(clock_sec, clock_nsec, pick_accel(), pick_accel(), pick_rate());
  endtask

  // receiver: check result items and stall at random
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        sb.check_result({out_sec, out_nanosec, pos_east, pos_north, heading, vel_fwd,
                         vel_side, yaw_rate_avg, accel_fwd_out, accel_side_out, yaw_accel});
        progress++;
      end
      out_stall <= hold_receiver || ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // watchdog on cycles without any accepted item
  initial begin
    int idle_cycles;
    int last_progress;
    idle_cycles = 0;
    last_progress = 0;
    forever begin
      @(posedge clk);
      if (progress != last_progress) begin
        last_progress = progress;
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("no progress for %0d cycles", IDLE_LIMIT);
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  // long receiver hold-off while the sender keeps offering items
  task hold_output();
    hold_receiver = 1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_receiver = 0;
  endtask

  initial begin
    sb = new();
    sender_idle_pct = 24;
    receiver_idle_pct = 60;
    hold_receiver = 0;
    progress = 0;
    samples_sent = 0;
    rst <= 1;
    in_valid <= 0;
    out_stall <= 0;
    stamp_sec <= 0;
    stamp_nanosec <= 0;
    accel_fwd <= 0;
    accel_side <= 0;
    yaw_rate_raw <= 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: first sample, zero and backward steps, cap, nanosecond overrange
    send_sample(32'd10, 30'd0, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_sample(32'd10, 30'd0, 32'h00010000, 32'hffff0000, 32'h01000000);
    send_sample(32'd10, 30'd10000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_sample(32'd9, 30'd999999999, 32'h00020000, 32'h00000000, 32'h80000000);
    send_sample(32'd10, 30'd20000000, 32'h80000000, 32'h7fffffff, 32'h80000000);
    send_sample(32'd10, 30'h3fffffff, 32'h00000000, 32'h00000000, 32'h00000000);
    send_sample(32'd12, 30'd0, 32'hffffffff, 32'h00000001, 32'hffffffff);
    send_sample(32'hffffffff, 30'd999999999, 32'h00001000, 32'h00001000, 32'h00000001);
    send_sample(32'h00000000, 30'd0, 32'h00001000, 32'h00001000, 32'h00000000);
    send_sample(32'h00000001, 30'd1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_sample(32'h00100000, 30'd500000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_sample(32'h00100001, 30'd0, 32'h80000000, 32'h80000000, 32'h80000000);
    send_sample(32'h00100001, 30'd1, 32'h12345678, 32'hedcba987, 32'h55555555);
    send_sample(32'h00100001, 30'd2, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa);
    for (int i = 0; i < 8; i++)
      send_sample(32'h00100002 + i, 30'd0, 32'h00008000, 32'hffff8000, pick_rate());
    clock_sec = 32'h00100010;
    clock_nsec = 30'd0;

    // random phases with changing idle patterns
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        sender_idle_pct = 60;
        receiver_idle_pct = 24;
      end else if (phase == 2) begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      if (phase == 2) begin
        fork
          hold_output();
          for (int i = 0; i < 580; i++) random_sample();
        join
      end else begin
        for (int i = 0; i < 580; i++) random_sample();
      end
    end
    in_valid <= 0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d samples sent, %0d results checked over three idle patterns",
             samples_sent, sb.checked);
    $display("covered zero, backward and capped time steps and field extremes");
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
